// File: hw/rtl/snapshot_slot_replacement_defines.svh
// Assertion macros for the snapshot slot replacement block.
`ifndef SNAPSHOT_SLOT_REPLACEMENT_DEFINES_SVH
`define SNAPSHOT_SLOT_REPLACEMENT_DEFINES_SVH

// Clocked assertion, held off during reset.
`define SSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must never hold.
`define SSR_NEVER(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// File: hw/rtl/ssr_pkg.sv
// Shared types and codes for the snapshot slot replacement block.
package ssr_pkg;

    localparam int IDX_W = 6;   // holds a slot index for tables up to 64 slots
    localparam int CNT_W = 7;   // holds a slot count up to 64

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [1:0] OP_CAPTURE = 2'd0;
    localparam logic [1:0] OP_FIND    = 2'd1;
    localparam logic [1:0] OP_DROP    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_STALE  = 2'd2;
    localparam logic [1:0] ST_FAILED = 2'd3;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_DROP  = 3'd3;
    localparam logic [2:0] CMD_TOUCH = 3'd4;

    typedef struct packed {
        logic [15:0] ses;
        logic [15:0] vol;
        logic [31:0] dir;
        logic [31:0] gen;
        logic [31:0] mut;
        logic        any_s;
        logic        any_v;
    } req_t;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic        active;
        logic        hit;
        idx_t        hit_idx;
        logic        stale;
        logic        own_found;
        idx_t        own_idx;
        logic [63:0] own_time;
        cnt_t        held;
        logic        free_found;
        idx_t        free_idx;
        logic        glob_found;
        idx_t        glob_idx;
        logic [63:0] glob_time;
        cnt_t        drops;
    } carry_t;

    typedef struct packed {
        logic [2:0]  kind;
        idx_t        idx;
        logic [63:0] stamp;
    } cmd_t;

endpackage

// File: hw/rtl/snapshot_slot_replacement.sv
// Snapshot slot replacement: top level with request control and the slot chain.
// For each accepted request a scan token walks the row of slot cells one cell
// per cycle, gathering key hit, per-session and global least recently used
// slots, the first free slot and drop matches, then the apply state applies the
// chosen update and loads the result register. The apply state waits while the
// result register still holds an unaccepted beat. A new request is taken while a
// result still waits.
`include "snapshot_slot_replacement_defines.svh"

module snapshot_slot_replacement #(
    parameter int SLOTS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_data,     // per_session_share
    input  logic         in_tvalid,
    output logic         in_tready,
    // session[15:0] volume[31:16] directory_id[63:32] catalog_generation[95:64]
    // mutation_count[127:96] capture_ok[128] any_session[129] any_volume[130]
    input  logic [135:0] in_tdata,
    input  logic [1:0]   in_tuser,     // operation
    output logic         out_tvalid,
    input  logic         out_tready,
    // slot_index[2:0] status[4:3] evicted[5] dropped_count[9:6]
    output logic [15:0]  out_tdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [3:0]      share_reg;
    logic [63:0]     use_reg;
    logic [63:0]     use_next;
    logic            start_reg;
    logic [1:0]      op_reg;
    logic            ok_reg;
    ssr_pkg::req_t   req_reg;
    ssr_pkg::carry_t scan_reg;
    ssr_pkg::carry_t start_carry;
    ssr_pkg::carry_t chain [SLOTS+1];
    ssr_pkg::cmd_t   cmd;
    logic            out_valid_reg;
    logic [15:0]     out_data_reg;
    logic [15:0]     out_data_next;
    logic            out_free;
    logic            in_acc;

    ssr_pkg::idx_t   pick_idx;
    logic            pick_ev;
    logic [2:0]      res_idx;
    logic [1:0]      res_status;
    logic            res_ev;
    logic [3:0]      res_drop;

    assign in_tready  = (state_reg == ST_IDLE);
    assign in_acc     = in_tvalid && in_tready;
    assign out_free   = !out_valid_reg || out_tready;
    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

    always_comb
    begin
        start_carry        = '0;
        start_carry.active = start_reg;
    end
    assign chain[0] = start_carry;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ssr_cell #(.IDX(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req       (req_reg),
            .cmd       (cmd),
            .carry_in  (chain[g]),
            .carry_out (chain[g+1])
        );
    end

    // Slot choice for a capture.
    always_comb
    begin
        if (scan_reg.hit)
        begin
            pick_idx = scan_reg.hit_idx;
            pick_ev  = 1'b0;
        end
        else if (scan_reg.own_found && (scan_reg.held >= ssr_pkg::cnt_t'(share_reg)))
        begin
            pick_idx = scan_reg.own_idx;
            pick_ev  = 1'b1;
        end
        else if (scan_reg.free_found)
        begin
            pick_idx = scan_reg.free_idx;
            pick_ev  = 1'b0;
        end
        else
        begin
            pick_idx = scan_reg.glob_found ? scan_reg.glob_idx : '0;
            pick_ev  = scan_reg.glob_found;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = ssr_pkg::CMD_NONE;
        cmd.stamp  = use_reg + 64'd1;
        use_next   = use_reg;
        res_idx    = 3'd0;
        res_status = ssr_pkg::ST_MISS;
        res_ev     = 1'b0;
        res_drop   = 4'd0;
        case (op_reg)
            ssr_pkg::OP_CAPTURE:
            begin
                cmd.idx = pick_idx;
                res_idx = pick_idx[2:0];
                res_ev  = pick_ev;
                if (ok_reg)
                begin
                    cmd.kind   = ssr_pkg::CMD_WRITE;
                    use_next   = use_reg + 64'd1;
                    res_status = ssr_pkg::ST_OK;
                end
                else
                begin
                    cmd.kind   = ssr_pkg::CMD_CLEAR;
                    res_status = ssr_pkg::ST_FAILED;
                end
            end
            ssr_pkg::OP_FIND:
            begin
                if (scan_reg.hit)
                begin
                    cmd.idx = scan_reg.hit_idx;
                    res_idx = scan_reg.hit_idx[2:0];
                    if (scan_reg.stale)
                    begin
                        cmd.kind   = ssr_pkg::CMD_CLEAR;
                        res_status = ssr_pkg::ST_STALE;
                    end
                    else
                    begin
                        cmd.kind   = ssr_pkg::CMD_TOUCH;
                        use_next   = use_reg + 64'd1;
                        res_status = ssr_pkg::ST_OK;
                    end
                end
            end
            ssr_pkg::OP_DROP:
            begin
                cmd.kind   = ssr_pkg::CMD_DROP;
                res_status = ssr_pkg::ST_OK;
                res_drop   = scan_reg.drops[3:0];
            end
            default: ;
        endcase
        if (!((state_reg == ST_APPLY) && out_free))
        begin
            cmd.kind = ssr_pkg::CMD_NONE;
            use_next = use_reg;
        end
        out_data_next = {6'd0, res_drop, res_ev, res_status, res_idx};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_SCAN;
            ST_SCAN:  if (chain[SLOTS].active) state_next = ST_APPLY;
            ST_APPLY: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            share_reg     <= 4'd4;
            use_reg       <= 64'd0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            use_reg   <= use_next;
            start_reg <= in_acc;
            if (cfg_we)
            begin
                share_reg <= cfg_data;
            end
            if ((state_reg == ST_APPLY) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg        <= in_tuser;
            req_reg.ses   <= in_tdata[15:0];
            req_reg.vol   <= in_tdata[31:16];
            req_reg.dir   <= in_tdata[63:32];
            req_reg.gen   <= in_tdata[95:64];
            req_reg.mut   <= in_tdata[127:96];
            ok_reg        <= in_tdata[128];
            req_reg.any_s <= in_tdata[129];
            req_reg.any_v <= in_tdata[130];
        end
        if (chain[SLOTS].active)
        begin
            scan_reg <= chain[SLOTS];
        end
        if ((state_reg == ST_APPLY) && out_free)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `SSR_ASSERT(a_accept_starts_scan, in_acc |=> (state_reg == ST_SCAN),
        "accepted request did not start a scan")
    `SSR_ASSERT(a_token_only_in_scan, chain[SLOTS].active |-> (state_reg == ST_SCAN),
        "scan token left the chain outside a scan")
    `SSR_NEVER(a_write_needs_capture,
        (cmd.kind == ssr_pkg::CMD_WRITE) && !((op_reg == ssr_pkg::OP_CAPTURE) && ok_reg),
        "slot written outside a successful capture")

endmodule

// File: hw/rtl/ssr_cell.sv
// One table slot: holds its entry and folds it into the passing scan token.
module ssr_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ssr_pkg::req_t   req,
    input  ssr_pkg::cmd_t   cmd,
    input  ssr_pkg::carry_t carry_in,
    output ssr_pkg::carry_t carry_out
);

    localparam ssr_pkg::idx_t MY_IDX = ssr_pkg::idx_t'(IDX);

    logic            valid_reg;
    logic [15:0]     ses_reg;
    logic [15:0]     vol_reg;
    logic [31:0]     dir_reg;
    logic [31:0]     gen_reg;
    logic [31:0]     mut_reg;
    logic [63:0]     lru_reg;
    ssr_pkg::carry_t carry_reg;
    ssr_pkg::carry_t carry_next;

    logic ses_m;
    logic key_m;
    logic drop_m;
    logic mine;

    assign ses_m  = valid_reg && (ses_reg == req.ses);
    assign key_m  = ses_m && (vol_reg == req.vol) && (dir_reg == req.dir);
    assign drop_m = valid_reg && (req.any_s || (ses_reg == req.ses))
                    && (req.any_v || (vol_reg == req.vol));
    assign mine   = (cmd.idx == MY_IDX);

    always_comb
    begin
        carry_next = carry_in;
        if (key_m && !carry_in.hit)
        begin
            carry_next.hit     = 1'b1;
            carry_next.hit_idx = MY_IDX;
            carry_next.stale   = (gen_reg != req.gen) || (mut_reg != req.mut);
        end
        if (ses_m)
        begin
            carry_next.held = carry_in.held + 1'b1;
            if (!carry_in.own_found || (lru_reg < carry_in.own_time))
            begin
                carry_next.own_found = 1'b1;
                carry_next.own_idx   = MY_IDX;
                carry_next.own_time  = lru_reg;
            end
        end
        if (!valid_reg && !carry_in.free_found)
        begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx   = MY_IDX;
        end
        if (valid_reg && (!carry_in.glob_found || (lru_reg < carry_in.glob_time)))
        begin
            carry_next.glob_found = 1'b1;
            carry_next.glob_idx   = MY_IDX;
            carry_next.glob_time  = lru_reg;
        end
        if (drop_m)
        begin
            carry_next.drops = carry_in.drops + 1'b1;
        end
        if (!carry_in.active)
        begin
            carry_next.active = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            case (cmd.kind)
                ssr_pkg::CMD_WRITE: if (mine) valid_reg <= 1'b1;
                ssr_pkg::CMD_CLEAR: if (mine) valid_reg <= 1'b0;
                ssr_pkg::CMD_DROP:  if (drop_m) valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mine && (cmd.kind == ssr_pkg::CMD_WRITE))
        begin
            ses_reg <= req.ses;
            vol_reg <= req.vol;
            dir_reg <= req.dir;
            gen_reg <= req.gen;
            mut_reg <= req.mut;
        end
        if (mine && ((cmd.kind == ssr_pkg::CMD_WRITE) || (cmd.kind == ssr_pkg::CMD_TOUCH)))
        begin
            lru_reg <= cmd.stamp;
        end
    end

    assign carry_out = carry_reg;

endmodule
